// ===== hw/rtl/cbc_pkg.sv =====
package cbc_pkg;

    localparam int ROM_BANK_BITS_DEF = 7;
    localparam int RAM_BANK_COUNT    = 4;
    localparam int CLOCK_REG_COUNT   = 5;
    localparam int CLK_IDX_W         = 3;
    localparam int RAM_SEL_W         = 2;
    localparam int PADDR_W           = 3;
    localparam int PDATA_W           = 32;

    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_ROM  = 2'd1,
        TGT_RAM  = 2'd2,
        TGT_CLK  = 2'd3
    } t_target;

    typedef enum logic [1:0] {
        AREA_RAM_ENABLE = 2'd0,
        AREA_ROM_BANK   = 2'd1,
        AREA_SELECT     = 2'd2,
        AREA_LATCH      = 2'd3
    } t_wr_area;

    typedef enum logic {
        CFG_ROM_BANK_COUNT = 1'b0,
        CFG_RAM_SIZE_BYTES = 1'b1
    } t_cfg_idx;

    localparam logic ACT_WRITE = 1'b1;

    localparam logic [7:0] RAM_ENABLE_KEY  = 8'h0A;
    localparam logic [7:0] RAM_ENABLE_MASK = 8'h0F;
    localparam logic [7:0] ROM_BANK_MASK   = 8'h7F;
    localparam logic [7:0] OPEN_BUS        = 8'hFF;
    localparam logic [7:0] LATCH_ARM       = 8'h00;
    localparam logic [7:0] LATCH_FIRE      = 8'h01;
    localparam logic [7:0] SEL_CLK_FIRST   = 8'h08;
    localparam logic [7:0] SEL_CLK_LAST    = 8'h0C;
    localparam logic [2:0] REGION_CART_RAM = 3'b101;

    localparam logic [CLK_IDX_W-1:0] CLK_S  = 3'd0;
    localparam logic [CLK_IDX_W-1:0] CLK_M  = 3'd1;
    localparam logic [CLK_IDX_W-1:0] CLK_H  = 3'd2;
    localparam logic [CLK_IDX_W-1:0] CLK_DL = 3'd3;
    localparam logic [CLK_IDX_W-1:0] CLK_DH = 3'd4;

    localparam logic [7:0]  ROM_BANK_COUNT_RST = 8'd128;
    localparam logic [15:0] RAM_SIZE_RST       = 16'd32768;

    typedef struct packed {
        logic        action;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [5:0]  now_seconds;
        logic [5:0]  now_minutes;
        logic [4:0]  now_hours;
        logic [8:0]  now_day;
    } t_item;

    typedef struct packed {
        t_target     target;
        logic [20:0] mem_offset;
        logic        ram_write;
        logic [7:0]  read_data;
    } t_result;

    typedef struct packed {
        logic [7:0]  rom_bank_count;
        logic [15:0] ram_size_bytes;
    } t_cfg;

endpackage

// ===== hw/rtl/cbc_apb_regs.sv =====
module cbc_apb_regs import cbc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_cfg_idx idx;
    logic     wr_en;

    assign idx    = t_cfg_idx'(paddr[2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rom_bank_count <= ROM_BANK_COUNT_RST;
            r_cfg.ram_size_bytes <= RAM_SIZE_RST;
        end else if (wr_en) begin
            unique case (idx)
                CFG_ROM_BANK_COUNT: r_cfg.rom_bank_count <= pwdata[7:0];
                CFG_RAM_SIZE_BYTES: r_cfg.ram_size_bytes <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            CFG_ROM_BANK_COUNT: prdata = {24'd0, r_cfg.rom_bank_count};
            CFG_RAM_SIZE_BYTES: prdata = {16'd0, r_cfg.ram_size_bytes};
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/cbc_core.sv =====
module cbc_core import cbc_pkg::*; #(
    parameter int ROM_BANK_BITS = ROM_BANK_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam int BANK_W = (ROM_BANK_BITS < 7) ? ROM_BANK_BITS : 7;

    logic [BANK_W-1:0] r_rom_bank;
    logic [7:0]        r_select;
    logic              r_ram_en;
    logic [7:0]        r_last_latch;
    logic [7:0]        r_live    [CLOCK_REG_COUNT];
    logic [7:0]        r_latched [CLOCK_REG_COUNT];

    logic                 is_write;
    t_wr_area             wr_area;
    logic [7:0]           bank_mask;
    logic [7:0]           bank_raw;
    logic [7:0]           bank;
    logic                 bank_oob;
    logic                 in_ram_area;
    logic                 sel_ram;
    logic                 sel_clk;
    logic [14:0]          ram_off;
    logic                 ram_hit;
    logic [7:0]           clk_diff;
    logic [CLK_IDX_W-1:0] clk_idx;
    logic                 latch_fire;
    logic [7:0]           bank_wr_masked;
    logic [BANK_W-1:0]    n_rom_bank;

    assign is_write    = (i_item.action == ACT_WRITE);
    assign wr_area     = t_wr_area'(i_item.address[14:13]);
    assign bank_mask   = i_cfg.rom_bank_count - 8'd1;
    assign bank_raw    = {{(8-BANK_W){1'b0}}, r_rom_bank} & bank_mask;
    assign bank        = (bank_raw == 8'd0) ? 8'd1 : bank_raw;
    assign bank_oob    = (i_cfg.rom_bank_count != 8'd0) && (bank >= i_cfg.rom_bank_count);
    assign in_ram_area = (i_item.address[15:13] == REGION_CART_RAM) && r_ram_en;
    assign sel_ram     = r_select < 8'(RAM_BANK_COUNT);
    assign sel_clk     = (r_select >= SEL_CLK_FIRST) && (r_select <= SEL_CLK_LAST);
    assign ram_off     = {r_select[RAM_SEL_W-1:0], i_item.address[12:0]};
    assign ram_hit     = {1'b0, ram_off} < i_cfg.ram_size_bytes;
    assign clk_diff    = r_select - SEL_CLK_FIRST;
    assign clk_idx     = clk_diff[CLK_IDX_W-1:0];
    assign latch_fire  = is_write && !i_item.address[15] && (wr_area == AREA_LATCH)
                         && (r_last_latch == LATCH_ARM) && (i_item.write_data == LATCH_FIRE);

    assign bank_wr_masked = i_item.write_data & ROM_BANK_MASK;
    assign n_rom_bank     = (bank_wr_masked[BANK_W-1:0] == '0) ? BANK_W'(1)
                                                              : bank_wr_masked[BANK_W-1:0];

    always_comb begin
        o_result.target     = TGT_NONE;
        o_result.mem_offset = '0;
        o_result.ram_write  = 1'b0;
        o_result.read_data  = OPEN_BUS;
        if (!i_item.address[15]) begin
            if (!is_write) begin
                if (!i_item.address[14]) begin
                    o_result.target     = TGT_ROM;
                    o_result.mem_offset = {5'd0, i_item.address};
                    o_result.read_data  = 8'd0;
                end else if (!bank_oob) begin
                    o_result.target     = TGT_ROM;
                    o_result.mem_offset = {bank[6:0], i_item.address[13:0]};
                    o_result.read_data  = 8'd0;
                end
            end
        end else if (in_ram_area) begin
            if (sel_ram) begin
                if (ram_hit) begin
                    o_result.target     = TGT_RAM;
                    o_result.mem_offset = {6'd0, ram_off};
                    o_result.ram_write  = is_write;
                    o_result.read_data  = 8'd0;
                end
            end else if (sel_clk) begin
                o_result.target    = TGT_CLK;
                o_result.read_data = is_write ? 8'd0 : r_latched[clk_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_bank   <= BANK_W'(1);
            r_select     <= 8'd0;
            r_ram_en     <= 1'b0;
            r_last_latch <= OPEN_BUS;
            for (int i = 0; i < CLOCK_REG_COUNT; i++) begin
                r_live[i]    <= 8'd0;
                r_latched[i] <= 8'd0;
            end
        end else if (i_advance) begin
            if (is_write && !i_item.address[15]) begin
                unique case (wr_area)
                    AREA_RAM_ENABLE: begin
                        r_ram_en <= (i_item.write_data & RAM_ENABLE_MASK) == RAM_ENABLE_KEY;
                    end
                    AREA_ROM_BANK: r_rom_bank <= n_rom_bank;
                    AREA_SELECT:   r_select   <= i_item.write_data;
                    AREA_LATCH: begin
                        r_last_latch <= i_item.write_data;
                        if (latch_fire) begin
                            r_live[CLK_S]     <= {2'd0, i_item.now_seconds};
                            r_live[CLK_M]     <= {2'd0, i_item.now_minutes};
                            r_live[CLK_H]     <= {3'd0, i_item.now_hours};
                            r_live[CLK_DL]    <= i_item.now_day[7:0];
                            r_live[CLK_DH]    <= {r_live[CLK_DH][7:1], i_item.now_day[8]};
                            r_latched[CLK_S]  <= {2'd0, i_item.now_seconds};
                            r_latched[CLK_M]  <= {2'd0, i_item.now_minutes};
                            r_latched[CLK_H]  <= {3'd0, i_item.now_hours};
                            r_latched[CLK_DL] <= i_item.now_day[7:0];
                            r_latched[CLK_DH] <= {r_live[CLK_DH][7:1], i_item.now_day[8]};
                        end
                    end
                    default: ;
                endcase
            end else if (is_write && in_ram_area && !sel_ram && sel_clk) begin
                r_live[clk_idx] <= i_item.write_data;
            end
        end
    end

endmodule

// ===== hw/rtl/cartridge_bank_controller_rtc_top.sv =====
// Cartridge bank controller with clock registers. Each input beat is one CPU
// bus access and gives exactly one result beat. An access waits in the input
// register and is decoded, with its register update, on the way into the
// result register; one access is taken every cycle while the result side does
// not stall. The input register also buffers one access while a result is
// held; o_stall is high while it holds one that cannot advance. The user must
// write configuration over APB only with no access in flight; not enforced.
module cartridge_bank_controller_rtc_top import cbc_pkg::*; #(
    parameter int ROM_BANK_BITS = ROM_BANK_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_action,
    input  logic [15:0]        i_address,
    input  logic [7:0]         i_write_data,
    input  logic [5:0]         i_now_seconds,
    input  logic [5:0]         i_now_minutes,
    input  logic [4:0]         i_now_hours,
    input  logic [8:0]         i_now_day,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_target,
    output logic [20:0]        o_mem_offset,
    output logic               o_ram_write,
    output logic [7:0]         o_read_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg    cfg;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;
    logic    advance;
    logic    accept_in;

    assign advance   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !advance;
    assign accept_in = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in.action      <= i_action;
            r_in.address     <= i_address;
            r_in.write_data  <= i_write_data;
            r_in.now_seconds <= i_now_seconds;
            r_in.now_minutes <= i_now_minutes;
            r_in.now_hours   <= i_now_hours;
            r_in.now_day     <= i_now_day;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    cbc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cbc_core #(
        .ROM_BANK_BITS (ROM_BANK_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in),
        .i_cfg     (cfg),
        .o_result  (n_out)
    );

    assign o_valid      = r_out_valid;
    assign o_target     = r_out.target;
    assign o_mem_offset = r_out.mem_offset;
    assign o_ram_write  = r_out.ram_write;
    assign o_read_data  = r_out.read_data;

endmodule

// ===== hw/rtl/cbc_checker.sv =====
module cbc_checker import cbc_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_target,
    input logic [20:0] o_mem_offset,
    input logic        o_ram_write,
    input logic [7:0]  o_read_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_target) && $stable(o_mem_offset))
        else $error("result beat changed under stall");

    a_open_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_target == TGT_NONE) |->
            (o_read_data == OPEN_BUS) && (o_mem_offset == 21'd0) && !o_ram_write)
        else $error("open bus beat carries data");

    a_ram_write_tgt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ram_write |-> (o_target == TGT_RAM) && (o_mem_offset[20:15] == 6'd0))
        else $error("RAM write outside cart RAM");

    a_clk_tgt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_target == TGT_CLK) |-> (o_mem_offset == 21'd0) && !o_ram_write)
        else $error("clock register beat with memory offset");

endmodule

bind cartridge_bank_controller_rtc_top cbc_checker u_cbc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_target     (o_target),
    .o_mem_offset (o_mem_offset),
    .o_ram_write  (o_ram_write),
    .o_read_data  (o_read_data)
);

// ===== dv/cartridge_bank_controller_rtc_top_tb.sv =====
module cartridge_bank_controller_rtc_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbc_pkg::*;

    localparam logic ACT_READ = 1'b0;
    localparam t_result OPEN_RES = '{TGT_NONE, 21'd0, 1'b0, OPEN_BUS};
    localparam int RAND_PER_PHASE = 170;
    localparam int NUM_PHASES = 8;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    typedef struct {
        t_item   acc;
        logic    fixed;
        t_result res;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_action;
    logic [15:0]        i_address;
    logic [7:0]         i_write_data;
    logic [5:0]         i_now_seconds;
    logic [5:0]         i_now_minutes;
    logic [4:0]         i_now_hours;
    logic [8:0]         i_now_day;
    logic               o_valid;
    logic               i_stall;
    logic [1:0]         o_target;
    logic [20:0]        o_mem_offset;
    logic               o_ram_write;
    logic [7:0]         o_read_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    cartridge_bank_controller_rtc_top dut (.*);

    // side-band sent along with each beat: hand-typed expectation for directed rows
    logic    item_fixed;
    t_result item_fixed_res;

    // controller state as the testbench sees it
    logic [7:0]                   cfg_banks;
    logic [15:0]                  cfg_ram_bytes;
    logic [ROM_BANK_BITS_DEF-1:0] bank_reg;
    logic [7:0]                   sel_reg;
    logic                         ram_en;
    logic [7:0]                   prev_latch;
    logic [7:0]                   live_clk [CLOCK_REG_COUNT];
    logic [7:0]                   held_clk [CLOCK_REG_COUNT];

    t_result  decodes_due [$];
    t_dir_row dir_rows [$];
    int       mismatches = 0;
    int       burst_left = 0;

    int          stall_left = 0;
    int          stall_cyc = 0;
    t_stall_mode stall_mode = STALL_NONE;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("** cartridge_bank_controller_rtc_top: FAILED **");
        $finish;
    end

    function automatic void reset_model();
        cfg_banks     = ROM_BANK_COUNT_RST;
        cfg_ram_bytes = RAM_SIZE_RST;
        bank_reg      = ROM_BANK_BITS_DEF'(1);
        sel_reg       = 8'h00;
        ram_en        = 1'b0;
        prev_latch    = 8'hFF;
        for (int i = 0; i < CLOCK_REG_COUNT; i++) begin
            live_clk[i] = 8'h00;
            held_clk[i] = 8'h00;
        end
    endfunction

    function automatic t_result decode_access(t_item a);
        t_result    r;
        logic [7:0] mask;
        int         bank;
        int         limit;
        int         off;
        int         idx;
        r = OPEN_RES;
        if (!a.address[15]) begin
            if (a.action != ACT_WRITE) begin
                if (!a.address[14]) begin
                    r = '{TGT_ROM, 21'(a.address), 1'b0, 8'h00};
                end else begin
                    mask = cfg_banks - 8'd1;
                    bank = int'({1'b0, bank_reg} & mask);
                    if (bank == 0) bank = 1;
                    limit = (cfg_banks == 8'd0) ? 256 : int'(cfg_banks);
                    if (bank < limit) begin
                        r = '{TGT_ROM, 21'(int'(a.address[13:0]) + bank * 'h4000), 1'b0, 8'h00};
                    end
                end
            end else begin
                case (t_wr_area'(a.address[14:13]))
                    AREA_RAM_ENABLE: ram_en = (a.write_data & RAM_ENABLE_MASK) == RAM_ENABLE_KEY;
                    AREA_ROM_BANK: begin
                        bank_reg = a.write_data[ROM_BANK_BITS_DEF-1:0]
                                 & ROM_BANK_MASK[ROM_BANK_BITS_DEF-1:0];
                        if (bank_reg == 0) bank_reg = ROM_BANK_BITS_DEF'(1);
                    end
                    AREA_SELECT: sel_reg = a.write_data;
                    AREA_LATCH: begin
                        if (prev_latch == LATCH_ARM && a.write_data == LATCH_FIRE) begin
                            live_clk[CLK_S]  = {2'b00, a.now_seconds};
                            live_clk[CLK_M]  = {2'b00, a.now_minutes};
                            live_clk[CLK_H]  = {3'b000, a.now_hours};
                            live_clk[CLK_DL] = a.now_day[7:0];
                            // DH keeps bits 7..1, only the day carry bit moves
                            live_clk[CLK_DH] = {live_clk[CLK_DH][7:1], a.now_day[8]};
                            held_clk = live_clk;
                        end
                        prev_latch = a.write_data;
                    end
                endcase
            end
        end else if (a.address[15:13] == REGION_CART_RAM && ram_en) begin
            if (sel_reg < RAM_BANK_COUNT) begin
                off = int'(a.address[12:0]) + int'(sel_reg) * 'h2000;
                if (cfg_ram_bytes != 16'd0 && off < int'(cfg_ram_bytes)) begin
                    r = '{TGT_RAM, 21'(off), a.action == ACT_WRITE, 8'h00};
                end
            end else if (sel_reg >= SEL_CLK_FIRST && sel_reg <= SEL_CLK_LAST) begin
                idx = int'(sel_reg - SEL_CLK_FIRST);
                if (a.action == ACT_WRITE) begin
                    live_clk[idx] = a.write_data;
                    r = '{TGT_CLK, 21'd0, 1'b0, 8'h00};
                end else begin
                    r = '{TGT_CLK, 21'd0, 1'b0, held_clk[idx]};
                end
            end
        end
        return r;
    endfunction

    function automatic t_item bus_acc(logic act, logic [15:0] addr, logic [7:0] data);
        t_item a;
        a = '0;
        a.action     = act;
        a.address    = addr;
        a.write_data = data;
        return a;
    endfunction

    function automatic t_item timed_acc(t_item a, logic [5:0] sec, logic [5:0] mins,
                                        logic [4:0] hrs, logic [8:0] day);
        a.now_seconds = sec;
        a.now_minutes = mins;
        a.now_hours   = hrs;
        a.now_day     = day;
        return a;
    endfunction

    function automatic t_item random_time(t_item a);
        if ($urandom_range(0, 4) == 0) begin
            return timed_acc(a, 6'($urandom), 6'($urandom), 5'($urandom), 9'($urandom));
        end
        return timed_acc(a, 6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)),
                         5'($urandom_range(0, 23)), 9'($urandom_range(0, 365)));
    endfunction

    function automatic t_item random_access();
        t_item a;
        int    kind;
        int    pick;
        a = random_time(bus_acc(1'($urandom), 16'($urandom), 8'($urandom)));
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            // raw noise
        end else if (kind < 26) begin
            a.action  = ACT_READ;
            a.address = {1'b0, 15'($urandom)};
        end else if (kind < 32) begin
            a.action  = ACT_WRITE;
            a.address = {3'b000, 13'($urandom)};
            if ($urandom_range(0, 3) != 0) a.write_data[3:0] = RAM_ENABLE_KEY[3:0];
        end else if (kind < 38) begin
            a.action  = ACT_WRITE;
            a.address = {3'b001, 13'($urandom)};
        end else if (kind < 46) begin
            a.action  = ACT_WRITE;
            a.address = {3'b010, 13'($urandom)};
            pick = $urandom_range(0, 9);
            if (pick < RAM_BANK_COUNT) a.write_data = 8'(pick);
            else if (pick < 9) a.write_data = SEL_CLK_FIRST + 8'(pick - RAM_BANK_COUNT);
        end else if (kind < 52) begin
            a.action  = ACT_WRITE;
            a.address = {3'b011, 13'($urandom)};
            if ($urandom_range(0, 3) != 0) a.write_data = {7'd0, 1'($urandom)};
        end else if (kind < 90) begin
            a.address = {REGION_CART_RAM, 13'($urandom)};
        end else if ($urandom_range(0, 1) == 0) begin
            a.address = {3'b100, 13'($urandom)};
        end else begin
            a.address = 16'($urandom_range('hC000, 'hFFFF));
        end
        return a;
    endfunction

    function automatic void add_fixed(t_item a, t_target t, logic [20:0] off, logic w,
                                      logic [7:0] rd);
        t_dir_row r;
        r.acc   = a;
        r.fixed = 1'b1;
        r.res   = '{t, off, w, rd};
        dir_rows.push_back(r);
    endfunction

    function automatic void add_predicted(t_item a);
        t_dir_row r;
        r.acc   = a;
        r.fixed = 1'b0;
        r.res   = OPEN_RES;
        dir_rows.push_back(r);
    endfunction

    task automatic send_access(t_item a, logic fixed, t_result res);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        i_valid        <= 1'b1;
        i_action       <= a.action;
        i_address      <= a.address;
        i_write_data   <= a.write_data;
        i_now_seconds  <= a.now_seconds;
        i_now_minutes  <= a.now_minutes;
        i_now_hours    <= a.now_hours;
        i_now_day      <= a.now_day;
        item_fixed     <= fixed;
        item_fixed_res <= res;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (decodes_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write then read back; psel stays high between the two transfers
    task automatic apb_write(t_cfg_idx idx, logic [31:0] val);
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == CFG_ROM_BANK_COUNT) begin
            cfg_banks = val[7:0];
            want = {24'd0, val[7:0]};
        end else begin
            cfg_ram_bytes = val[15:0];
            want = {16'd0, val[15:0]};
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $error("prdata: expected %0h, got %0h", want, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        stall_cyc++;
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default:     i_stall <= (stall_cyc % 5) < 2;
        endcase
    end

    always @(posedge i_clk) begin
        t_item   a;
        t_result want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                a = '{i_action, i_address, i_write_data, i_now_seconds, i_now_minutes,
                      i_now_hours, i_now_day};
                want = decode_access(a);
                if (item_fixed) want = item_fixed_res;
                decodes_due.push_back(want);
            end
            if (o_valid && !i_stall) begin
                if (decodes_due.size() == 0) begin
                    $error("result beat with no access outstanding");
                    mismatches++;
                end else begin
                    want = decodes_due.pop_front();
                    if (o_target !== want.target) begin
                        $error("target: expected %0d, got %0d", want.target, o_target);
                        mismatches++;
                    end
                    if (o_mem_offset !== want.mem_offset) begin
                        $error("mem_offset: expected %0h, got %0h", want.mem_offset,
                               o_mem_offset);
                        mismatches++;
                    end
                    if (o_ram_write !== want.ram_write) begin
                        $error("ram_write: expected %0d, got %0d", want.ram_write, o_ram_write);
                        mismatches++;
                    end
                    if (o_read_data !== want.read_data) begin
                        $error("read_data: expected %0h, got %0h", want.read_data, o_read_data);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        int          sent;
        int          reads;
        t_item       a;
        int unsigned phase_banks [NUM_PHASES];
        int unsigned phase_ram [NUM_PHASES];

        phase_banks = '{2, 0, 255, 16, 64, 1, 4, 128};
        phase_ram   = '{0, 65535, 1, 8192, 24576, 32768, 16384, 32768};

        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_action       <= ACT_READ;
        i_address      <= 16'h0000;
        i_write_data   <= 8'h00;
        i_now_seconds  <= 6'd0;
        i_now_minutes  <= 6'd0;
        i_now_hours    <= 5'd0;
        i_now_day      <= 9'd0;
        i_stall        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        item_fixed     <= 1'b0;
        item_fixed_res <= OPEN_RES;
        reset_model();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_fixed(bus_acc(ACT_READ, 16'h0000, 8'h00), TGT_ROM, 21'h0, 1'b0, 8'h00);
        add_fixed(bus_acc(ACT_READ, 16'h3FFF, 8'hFF), TGT_ROM, 21'h3FFF, 1'b0, 8'h00);
        add_fixed(bus_acc(ACT_READ, 16'h4000, 8'h00), TGT_ROM, 21'h4000, 1'b0, 8'h00);
        add_fixed(bus_acc(ACT_READ, 16'hA000, 8'h00), TGT_NONE, 21'h0, 1'b0, OPEN_BUS);
        add_fixed(bus_acc(ACT_READ, 16'h8000, 8'h00), TGT_NONE, 21'h0, 1'b0, OPEN_BUS);
        add_fixed(bus_acc(ACT_READ, 16'hFFFF, 8'h00), TGT_NONE, 21'h0, 1'b0, OPEN_BUS);
        add_fixed(bus_acc(ACT_WRITE, 16'h0000, RAM_ENABLE_KEY), TGT_NONE, 21'h0, 1'b0, OPEN_BUS);
        // bank 0 is bumped to 1
        add_fixed(bus_acc(ACT_WRITE, 16'h2000, 8'h00), TGT_NONE, 21'h0, 1'b0, OPEN_BUS);
        add_fixed(bus_acc(ACT_READ, 16'h7FFF, 8'h00), TGT_ROM, 21'h7FFF, 1'b0, 8'h00);
        add_predicted(bus_acc(ACT_WRITE, 16'h3FFF, 8'hFF));
        add_fixed(bus_acc(ACT_READ, 16'h7FFF, 8'h00), TGT_ROM, 21'h1FFFFF, 1'b0, 8'h00);
        add_predicted(bus_acc(ACT_WRITE, 16'h4000, 8'h03));
        add_fixed(bus_acc(ACT_WRITE, 16'hBFFF, 8'h55), TGT_RAM, 21'h7FFF, 1'b1, 8'h00);
        add_predicted(bus_acc(ACT_WRITE, 16'h5FFF, 8'h07));
        add_fixed(bus_acc(ACT_READ, 16'hA000, 8'h00), TGT_NONE, 21'h0, 1'b0, OPEN_BUS);
        add_predicted(bus_acc(ACT_WRITE, 16'h6000, LATCH_ARM));
        add_predicted(timed_acc(bus_acc(ACT_WRITE, 16'h7FFF, LATCH_FIRE),
                                6'h3F, 6'h3F, 5'h1F, 9'h1FF));
        add_predicted(bus_acc(ACT_WRITE, 16'h4000, SEL_CLK_LAST));
        add_fixed(bus_acc(ACT_READ, 16'hA000, 8'h00), TGT_CLK, 21'h0, 1'b0, 8'h01);
        add_fixed(bus_acc(ACT_WRITE, 16'hA000, 8'hFE), TGT_CLK, 21'h0, 1'b0, 8'h00);
        add_predicted(bus_acc(ACT_WRITE, 16'h6000, LATCH_ARM));
        add_predicted(timed_acc(bus_acc(ACT_WRITE, 16'h6000, LATCH_FIRE), 6'd0, 6'd0, 5'd0, 9'd0));
        add_fixed(bus_acc(ACT_READ, 16'hBFFF, 8'h00), TGT_CLK, 21'h0, 1'b0, 8'hFE);
        add_predicted(bus_acc(ACT_WRITE, 16'h4000, SEL_CLK_FIRST));
        add_predicted(bus_acc(ACT_READ, 16'hA123, 8'h00));

        foreach (dir_rows[i]) send_access(dir_rows[i].acc, dir_rows[i].fixed, dir_rows[i].res);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            apb_write(CFG_ROM_BANK_COUNT, phase_banks[p]);
            apb_write(CFG_RAM_SIZE_BYTES, phase_ram[p]);
            sent = 0;
            while (sent < RAND_PER_PHASE) begin
                if ($urandom_range(0, 11) == 0) begin
                    // latch the time, point at a clock register, then access it (mostly reads)
                    send_access(bus_acc(ACT_WRITE, {3'b011, 13'($urandom)}, LATCH_ARM),
                                1'b0, OPEN_RES);
                    send_access(random_time(bus_acc(ACT_WRITE, {3'b011, 13'($urandom)},
                                                    LATCH_FIRE)), 1'b0, OPEN_RES);
                    send_access(bus_acc(ACT_WRITE, {3'b010, 13'($urandom)},
                                        SEL_CLK_FIRST + 8'($urandom_range(0, 4))),
                                1'b0, OPEN_RES);
                    reads = $urandom_range(1, 3);
                    for (int r = 0; r < reads; r++) begin
                        a = bus_acc(1'($urandom_range(0, 3) == 0), {REGION_CART_RAM,
                                    13'($urandom)}, 8'($urandom));
                        send_access(a, 1'b0, OPEN_RES);
                    end
                    sent += 3 + reads;
                end else begin
                    send_access(random_access(), 1'b0, OPEN_RES);
                    sent++;
                end
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("** cartridge_bank_controller_rtc_top: PASSED **");
        end else begin
            $display("** cartridge_bank_controller_rtc_top: FAILED **");
        end
        $finish;
    end

endmodule
